FILE: rtl/core/cmbs_pkg.sv
`default_nettype none
package cmbs_pkg;

	localparam int CH_W    = 16;
	localparam int DIR_W   = 16;
	localparam int FACE_W  = 3;
	localparam int FACE_COUNT = 6;
	// queue fields sized for the largest face size and fraction width supported
	localparam int COORD_W = 10;
	localparam int FRAC_W  = 16;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		FACE_PX = 3'd0,
		FACE_NX = 3'd1,
		FACE_PY = 3'd2,
		FACE_NY = 3'd3,
		FACE_PZ = 3'd4,
		FACE_NZ = 3'd5
	} face_t;

	typedef struct packed {
		op_t                op;
		logic               zero;
		logic [FACE_W-1:0]  face;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] y1;
		logic [FRAC_W-1:0]  tx;
		logic [FRAC_W-1:0]  ty;
		logic [CH_W-1:0]    red;
		logic [CH_W-1:0]    green;
		logic [CH_W-1:0]    blue;
	} req_t;

endpackage
`default_nettype wire

FILE: rtl/core/cmbs_front.sv
`default_nettype none
module cmbs_front #(
	parameter int MAX_FACE_SIZE = 64,
	parameter int FRACTION_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [6:0]                  face_size,
	input  logic                        req_type,
	input  logic [2:0]                  write_face,
	input  logic [5:0]                  write_x,
	input  logic [5:0]                  write_y,
	input  logic [cmbs_pkg::CH_W-1:0]   write_red,
	input  logic [cmbs_pkg::CH_W-1:0]   write_green,
	input  logic [cmbs_pkg::CH_W-1:0]   write_blue,
	input  logic signed [cmbs_pkg::DIR_W-1:0] dir_x,
	input  logic signed [cmbs_pkg::DIR_W-1:0] dir_y,
	input  logic signed [cmbs_pkg::DIR_W-1:0] dir_z,
	input  logic                        q_full,
	output logic                        push,
	output cmbs_pkg::req_t              push_req
);
	import cmbs_pkg::*;

	localparam int F  = FRACTION_BITS;
	localparam int SW = $clog2(MAX_FACE_SIZE + 1);
	localparam int XW = (MAX_FACE_SIZE > 1) ? $clog2(MAX_FACE_SIZE) : 1;
	localparam int QW = SW + F;
	localparam int CW = $clog2(QW + 1);
	localparam logic [QW:0] HALF = (QW+1)'(1) << (F - 1);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_DIV  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t state_q;
	logic accept;
	logic [SW-1:0] size_c;
	logic wr_ok;

	logic signed [16:0] dxe, dye, dze, ax, ay, az, s_c, t_c, m_c, m_f;
	logic [FACE_W-1:0] face_c;
	logic signed [17:0] nx18, ny18;

	logic [FACE_W-1:0] face_q;
	logic [SW-1:0] size_q;
	logic [16:0] numx_q, numy_q, dvs_q;
	logic [16:0] remx_q, remy_q;
	logic [QW-1:0] nx_q, ny_q, qx_q, qy_q;
	logic [CW-1:0] cnt_q;

	logic [16+SW:0] prodx, prody;
	logic [17:0] rx2, ry2;
	logic [QW-1:0] hi, cx, cy;
	logic [XW-1:0] x0, y0;
	logic [SW-1:0] x0p1, y0p1, x1, y1;

	assign busy   = (state_q != F_IDLE) || q_full;
	assign accept = start && !busy;
	assign size_c = (32'(face_size) > MAX_FACE_SIZE) ? SW'(MAX_FACE_SIZE) : SW'(face_size);
	assign wr_ok  = (write_face < 3'(FACE_COUNT)) && (32'(write_x) < MAX_FACE_SIZE)
		&& (32'(write_y) < MAX_FACE_SIZE);

	// major axis, face and the two face-plane components
	always_comb begin
		dxe = 17'(dir_x);
		dye = 17'(dir_y);
		dze = 17'(dir_z);
		ax  = dxe[16] ? -dxe : dxe;
		ay  = dye[16] ? -dye : dye;
		az  = dze[16] ? -dze : dze;
		priority if (ax >= ay && ax >= az) begin
			m_c = ax;
			t_c = dye;
			if (dxe > 0) begin
				face_c = FACE_PX;
				s_c    = -dze;
			end else begin
				face_c = FACE_NX;
				s_c    = dze;
			end
		end else if (ay >= az) begin
			m_c = ay;
			s_c = dxe;
			if (dye > 0) begin
				face_c = FACE_PY;
				t_c    = -dze;
			end else begin
				face_c = FACE_NY;
				t_c    = dze;
			end
		end else begin
			m_c = az;
			t_c = dye;
			if (dze > 0) begin
				face_c = FACE_PZ;
				s_c    = dxe;
			end else begin
				face_c = FACE_NZ;
				s_c    = -dxe;
			end
		end
		m_f  = (m_c < 17'sd1) ? 17'sd1 : m_c;
		nx18 = 18'(s_c) + 18'(m_f);
		ny18 = 18'(m_f) - 18'(t_c);
	end

	assign prodx = numx_q * size_q;
	assign prody = numy_q * size_q;
	assign rx2 = {remx_q, nx_q[QW-1]};
	assign ry2 = {remy_q, ny_q[QW-1]};

	function automatic logic [QW-1:0] clampq(input logic [QW-1:0] q, input logic [QW-1:0] lim);
		logic [QW:0] c;
		c = {1'b0, q} - HALF;
		if (c[QW])
			return '0;
		else if (c[QW-1:0] > lim)
			return lim;
		else
			return c[QW-1:0];
	endfunction

	assign hi   = {size_q - SW'(1), {F{1'b0}}};
	assign cx   = clampq(qx_q, hi);
	assign cy   = clampq(qy_q, hi);
	assign x0   = cx[F +: XW];
	assign y0   = cy[F +: XW];
	assign x0p1 = SW'(x0) + SW'(1);
	assign y0p1 = SW'(y0) + SW'(1);
	assign x1   = (x0p1 < size_q) ? x0p1 : size_q - SW'(1);
	assign y1   = (y0p1 < size_q) ? y0p1 : size_q - SW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept && req_type == OP_SAMPLE && size_c != '0)
						state_q <= F_MUL;
				end
				F_MUL: begin
					state_q <= F_DIV;
					cnt_q   <= '0;
				end
				F_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(QW - 1))
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// restoring division, one quotient bit per cycle for both coordinates
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			face_q <= face_c;
			size_q <= size_c;
			numx_q <= nx18[16:0];
			numy_q <= ny18[16:0];
			dvs_q  <= {m_f[15:0], 1'b0};
		end
		if (state_q == F_MUL) begin
			remx_q <= prodx[16+SW:SW];
			remy_q <= prody[16+SW:SW];
			nx_q   <= {prodx[SW-1:0], {F{1'b0}}};
			ny_q   <= {prody[SW-1:0], {F{1'b0}}};
		end
		if (state_q == F_DIV) begin
			nx_q <= nx_q << 1;
			ny_q <= ny_q << 1;
			if (rx2 >= {1'b0, dvs_q}) begin
				remx_q <= 17'(rx2 - {1'b0, dvs_q});
				qx_q   <= {qx_q[QW-2:0], 1'b1};
			end else begin
				remx_q <= rx2[16:0];
				qx_q   <= {qx_q[QW-2:0], 1'b0};
			end
			if (ry2 >= {1'b0, dvs_q}) begin
				remy_q <= 17'(ry2 - {1'b0, dvs_q});
				qy_q   <= {qy_q[QW-2:0], 1'b1};
			end else begin
				remy_q <= ry2[16:0];
				qy_q   <= {qy_q[QW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		push     = 1'b0;
		push_req = '0;
		unique case (state_q)
			F_IDLE: begin
				if (accept && req_type == OP_WRITE) begin
					push           = wr_ok;
					push_req.op    = OP_WRITE;
					push_req.face  = write_face;
					push_req.x0    = COORD_W'(write_x);
					push_req.y0    = COORD_W'(write_y);
					push_req.red   = write_red;
					push_req.green = write_green;
					push_req.blue  = write_blue;
				end else if (accept && size_c == '0) begin
					push          = 1'b1;
					push_req.op   = OP_SAMPLE;
					push_req.zero = 1'b1;
					push_req.face = face_c;
				end
			end
			F_PUSH: begin
				push          = !q_full;
				push_req.op   = OP_SAMPLE;
				push_req.face = face_q;
				push_req.x0   = COORD_W'(x0);
				push_req.y0   = COORD_W'(y0);
				push_req.x1   = COORD_W'(x1);
				push_req.y1   = COORD_W'(y1);
				push_req.tx   = FRAC_W'(cx[F-1:0]);
				push_req.ty   = FRAC_W'(cy[F-1:0]);
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/cmbs_fifo.sv
`default_nettype none
module cmbs_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	logic [W-1:0] ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= wdata;
	end

endmodule
`default_nettype wire

FILE: rtl/core/cmbs_back.sv
`default_nettype none
module cmbs_back #(
	parameter int MAX_FACE_SIZE = 64,
	parameter int FRACTION_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  cmbs_pkg::req_t            head,
	output logic                      pop,
	output logic                      done,
	output logic [cmbs_pkg::CH_W-1:0] sample_red,
	output logic [cmbs_pkg::CH_W-1:0] sample_green,
	output logic [cmbs_pkg::CH_W-1:0] sample_blue,
	output logic [2:0]                hit_face
);
	import cmbs_pkg::*;

	localparam int F     = FRACTION_BITS;
	localparam int XW    = (MAX_FACE_SIZE > 1) ? $clog2(MAX_FACE_SIZE) : 1;
	localparam int DEPTH = FACE_COUNT * MAX_FACE_SIZE * MAX_FACE_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = 3 * CH_W;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_READ = 4'b0010,
		B_BOT  = 4'b0100,
		B_FIN  = 4'b1000
	} bstate_t;

	bstate_t state_q;
	logic [1:0] cnt_q;
	req_t cur_q;
	logic [TW-1:0] mem [DEPTH];
	logic [TW-1:0] rd_q, t00_q, top_q, bot_q;
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [XW-1:0] rx, ry;
	logic [TW-1:0] la, lb, lo;
	logic [F-1:0] lf;

	function automatic logic [AW-1:0] taddr(input logic [2:0] f, input logic [XW-1:0] x,
		input logic [XW-1:0] y);
		return AW'((int'(f) * MAX_FACE_SIZE + int'(y)) * MAX_FACE_SIZE + int'(x));
	endfunction

	function automatic logic [CH_W-1:0] lerp(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
		input logic [F-1:0] f);
		logic [F:0] inv;
		logic [CH_W+F:0] sum;
		inv = ((F+1)'(1) << F) - {1'b0, f};
		sum = (CH_W+F+1)'(a) * (CH_W+F+1)'(inv) + (CH_W+F+1)'(b) * (CH_W+F+1)'(f);
		return sum[F +: CH_W];
	endfunction

	assign pop   = (state_q == B_IDLE) && !q_empty;
	assign we    = pop && head.op == OP_WRITE;
	assign waddr = taddr(head.face, head.x0[XW-1:0], head.y0[XW-1:0]);

	// texel order: top-left, top-right, bottom-left, bottom-right
	always_comb begin
		rx = cnt_q[0] ? cur_q.x1[XW-1:0] : cur_q.x0[XW-1:0];
		ry = cnt_q[1] ? cur_q.y1[XW-1:0] : cur_q.y0[XW-1:0];
	end
	assign raddr = taddr(cur_q.face, rx, ry);

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= {head.red, head.green, head.blue};
		else
			rd_q <= mem[raddr];
	end

	always_comb begin
		if (state_q == B_FIN) begin
			la = top_q;
			lb = bot_q;
			lf = cur_q.ty[F-1:0];
		end else begin
			la = t00_q;
			lb = rd_q;
			lf = cur_q.tx[F-1:0];
		end
		for (int c = 0; c < 3; c++)
			lo[c*CH_W +: CH_W] = lerp(la[c*CH_W +: CH_W], lb[c*CH_W +: CH_W], lf);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= 2'd0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					cnt_q <= 2'd0;
					if (pop && head.op == OP_SAMPLE) begin
						if (head.zero)
							done <= 1'b1;
						else
							state_q <= B_READ;
					end
				end
				B_READ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3)
						state_q <= B_BOT;
				end
				B_BOT: state_q <= B_FIN;
				B_FIN: begin
					done    <= 1'b1;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		if (state_q == B_READ) begin
			if (cnt_q == 2'd1 || cnt_q == 2'd3)
				t00_q <= rd_q;
			if (cnt_q == 2'd2)
				top_q <= lo;
		end
		if (state_q == B_BOT)
			bot_q <= lo;
		if (state_q == B_IDLE && pop && head.op == OP_SAMPLE && head.zero) begin
			sample_red   <= '0;
			sample_green <= '0;
			sample_blue  <= '0;
			hit_face     <= head.face;
		end
		if (state_q == B_FIN) begin
			sample_red   <= lo[2*CH_W +: CH_W];
			sample_green <= lo[CH_W +: CH_W];
			sample_blue  <= lo[0 +: CH_W];
			hit_face     <= cur_q.face;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/cube_map_bilinear_sampler.sv
// Cube map sampler. A write request (req_type 0) stores one RGB texel; writes outside the
// six faces or with a coordinate of MAX_FACE_SIZE or more are dropped. A sample request
// (req_type 1) returns one result, shown for a single cycle with done high; the receiver
// cannot stall it, so capture it on that cycle. The front end selects the face and runs a
// bit-serial divider for the face coordinates and takes no new request until the
// sample has been pushed into the queue. The back end reads four texels from the
// single-port texel memory and blends them, behind a two-entry queue. busy drops
// when a request may be taken. Texels must be written before they are sampled; there
// is no clearing pass. face_size is to be written only while the block is idle; the
// block itself does not enforce this.
`default_nettype none
module cube_map_bilinear_sampler #(
	parameter int MAX_FACE_SIZE = 64,
	parameter int FRACTION_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      face_size_we,
	input  logic [6:0]                face_size,
	input  logic                      start,
	output logic                      busy,
	input  logic                      req_type,
	input  logic [2:0]                write_face,
	input  logic [5:0]                write_x,
	input  logic [5:0]                write_y,
	input  logic [cmbs_pkg::CH_W-1:0] write_red,
	input  logic [cmbs_pkg::CH_W-1:0] write_green,
	input  logic [cmbs_pkg::CH_W-1:0] write_blue,
	input  logic signed [cmbs_pkg::DIR_W-1:0] dir_x,
	input  logic signed [cmbs_pkg::DIR_W-1:0] dir_y,
	input  logic signed [cmbs_pkg::DIR_W-1:0] dir_z,
	output logic                      done,
	output logic [cmbs_pkg::CH_W-1:0] sample_red,
	output logic [cmbs_pkg::CH_W-1:0] sample_green,
	output logic [cmbs_pkg::CH_W-1:0] sample_blue,
	output logic [2:0]                hit_face
);
	import cmbs_pkg::*;

	logic [6:0] face_size_q;
	logic q_full, q_empty, push, pop;
	req_t push_req, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			face_size_q <= '0;
		else if (face_size_we)
			face_size_q <= face_size;
	end

	cmbs_front #(
		.MAX_FACE_SIZE(MAX_FACE_SIZE),
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.face_size(face_size_q), .req_type(req_type), .write_face(write_face),
		.write_x(write_x), .write_y(write_y), .write_red(write_red),
		.write_green(write_green), .write_blue(write_blue),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.q_full(q_full), .push(push), .push_req(push_req)
	);

	cmbs_fifo #(
		.W($bits(req_t))
	) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(push_req),
		.pop(pop), .rdata(head), .full(q_full), .empty(q_empty)
	);

	cmbs_back #(
		.MAX_FACE_SIZE(MAX_FACE_SIZE),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .head(head), .pop(pop),
		.done(done), .sample_red(sample_red), .sample_green(sample_green),
		.sample_blue(sample_blue), .hit_face(hit_face)
	);

endmodule
`default_nettype wire

FILE: rtl/core/cmbs_checker.sv
`default_nettype none
module cmbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        face_size_we,
	input logic [6:0]  face_size,
	input logic        done,
	input logic [15:0] sample_red,
	input logic [15:0] sample_green,
	input logic [15:0] sample_blue,
	input logic [2:0]  hit_face
);
	logic [6:0] fs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fs_q <= '0;
		else if (face_size_we)
			fs_q <= face_size;
	end

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> hit_face <= 3'd5)
		else $error("hit_face out of range");

	a_no_map_black: assert property (@(posedge clk) disable iff (!arst_n)
		done && fs_q == 7'd0 |-> sample_red == 16'd0 && sample_green == 16'd0
			&& sample_blue == 16'd0)
		else $error("nonzero color with no map");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !done)
		else $error("result right after reset");

endmodule

bind cube_map_bilinear_sampler cmbs_checker u_chk (.*);
`default_nettype wire

FILE: tb/sv/cube_map_bilinear_sampler_checker.sv
module cube_map_bilinear_sampler_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              face_size_we,
	input  logic [6:0]        face_size,
	input  logic              start,
	input  logic              busy,
	input  logic              req_type,
	input  logic [2:0]        write_face,
	input  logic [5:0]        write_x,
	input  logic [5:0]        write_y,
	input  logic [15:0]       write_red,
	input  logic [15:0]       write_green,
	input  logic [15:0]       write_blue,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic              done,
	input  logic [15:0]       sample_red,
	input  logic [15:0]       sample_green,
	input  logic [15:0]       sample_blue,
	input  logic [2:0]        hit_face,
	output int                errors,
	output int                pending,
	output int                samples_seen
);
	import cmbs_pkg::*;

	localparam int EDGE_MAX = 64;
	localparam int FB = 8;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [2:0]  face;
	} texel_result_t;

	logic [47:0]   texels [0:6*EDGE_MAX*EDGE_MAX-1];
	logic [6:0]    edge_len;
	texel_result_t sample_q [$];

	function automatic int texel_addr(int f, int x, int y);
		return (f * EDGE_MAX + y) * EDGE_MAX + x;
	endfunction

	function automatic int face_coord(longint num, longint m, int sz);
		longint q, c, hi;
		q = (num * sz * (64'sd1 << FB)) / (2 * m);
		c = q - (64'sd1 << (FB - 1));
		hi = longint'(sz - 1) * (64'sd1 << FB);
		if (c < 0) c = 0;
		if (c > hi) c = hi;
		return int'(c);
	endfunction

	function automatic longint blend(longint a, longint b, longint f);
		return (a * ((64'sd1 << FB) - f) + b * f) >>> FB;
	endfunction

	function automatic texel_result_t predict_sample(int dx, int dy, int dz, int size_cfg);
		texel_result_t r;
		int ax, ay, az, s, t, m, sz, fxq, fyq, x0, y0, x1, y1, tx, ty;
		face_t f;
		logic [47:0] c00, c10, c01, c11;
		longint top_c, bot_c;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		az = dz < 0 ? -dz : dz;
		if (ax >= ay && ax >= az) begin
			m = ax;
			if (dx > 0) begin f = FACE_PX; s = -dz; t = dy; end
			else begin f = FACE_NX; s = dz; t = dy; end
		end else if (ay >= az) begin
			m = ay;
			if (dy > 0) begin f = FACE_PY; s = dx; t = -dz; end
			else begin f = FACE_NY; s = dx; t = dz; end
		end else begin
			m = az;
			if (dz > 0) begin f = FACE_PZ; s = dx; t = dy; end
			else begin f = FACE_NZ; s = -dx; t = dy; end
		end
		if (m < 1) m = 1;
		sz = size_cfg > EDGE_MAX ? EDGE_MAX : size_cfg;
		r = '0;
		r.face = f;
		if (sz != 0) begin
			fxq = face_coord(longint'(s) + m, m, sz);
			fyq = face_coord(longint'(m) - t, m, sz);
			x0 = fxq >> FB;
			y0 = fyq >> FB;
			tx = fxq & ((1 << FB) - 1);
			ty = fyq & ((1 << FB) - 1);
			x1 = x0 + 1 < sz ? x0 + 1 : sz - 1;
			y1 = y0 + 1 < sz ? y0 + 1 : sz - 1;
			c00 = texels[texel_addr(f, x0, y0)];
			c10 = texels[texel_addr(f, x1, y0)];
			c01 = texels[texel_addr(f, x0, y1)];
			c11 = texels[texel_addr(f, x1, y1)];
			for (int c = 0; c < 3; c++) begin
				top_c = blend(c00[47-16*c -: 16], c10[47-16*c -: 16], tx);
				bot_c = blend(c01[47-16*c -: 16], c11[47-16*c -: 16], tx);
				r[50-16*c -: 16] = 16'(blend(top_c, bot_c, ty));
			end
		end
		return r;
	endfunction

	assign pending = sample_q.size();

	always @(posedge clk or negedge arst_n) begin
		texel_result_t exp_r;
		if (!arst_n) begin
			edge_len = '0;
			errors = 0;
			samples_seen = 0;
			sample_q.delete();
		end else begin
			if (done) begin
				samples_seen++;
				if (sample_q.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: rgb %h %h %h face %0d", $time,
						sample_red, sample_green, sample_blue, hit_face);
				end else begin
					exp_r = sample_q.pop_front();
					if (sample_red !== exp_r.red || sample_green !== exp_r.green ||
						sample_blue !== exp_r.blue || hit_face !== exp_r.face) begin
						errors++;
						$display("%0t: mismatch expected rgb %h %h %h face %0d, got %h %h %h face %0d",
							$time, exp_r.red, exp_r.green, exp_r.blue, exp_r.face,
							sample_red, sample_green, sample_blue, hit_face);
					end
				end
			end
			if (start && !busy) begin
				if (req_type == OP_WRITE) begin
					if (write_face < FACE_COUNT)
						texels[texel_addr(write_face, write_x, write_y)] =
							{write_red, write_green, write_blue};
				end else begin
					sample_q.push_back(predict_sample(dir_x, dir_y, dir_z, edge_len));
				end
			end
			if (face_size_we)
				edge_len = face_size;
		end
	end
endmodule

FILE: tb/sv/cube_map_bilinear_sampler_tb.sv
module cube_map_bilinear_sampler_tb;
	import cmbs_pkg::*;

	localparam int LIMIT = 3000000;
	// texel window loaded on every face for the largest face size
	localparam int WIN_LO = 29;
	localparam int WIN_HI = 34;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic face_size_we = 1'b0;
	logic [6:0] face_size = '0;
	logic start = 1'b0;
	logic busy, done;
	logic req_type = 1'b0;
	logic [2:0] write_face = '0;
	logic [5:0] write_x = '0, write_y = '0;
	logic [15:0] write_red = '0, write_green = '0, write_blue = '0;
	logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic [15:0] sample_red, sample_green, sample_blue;
	logic [2:0] hit_face;
	int errors, pending, samples_seen;
	int cycles = 0;
	int requests = 0;
	int gap_max = 0;
	bit centre_only = 1'b0;
	bit loaded [0:6*64*64-1];

	cube_map_bilinear_sampler u_top (.*);
	cube_map_bilinear_sampler_checker u_chk (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("cube_map_bilinear_sampler_tb: errors");
			$finish;
		end
	end

	// hold start until taken, then leave it high for the caller
	task automatic issue();
		start = 1'b1;
		while (busy) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
		requests++;
	endtask

	task automatic pause();
		int n;
		n = 0;
		if (gap_max > 0 && $urandom_range(0, 2) == 0)
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, gap_max) : $urandom_range(1, 3);
		if (n > 0) begin
			start = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic put_texel(int f, int x, int y, logic [15:0] r, logic [15:0] g,
		logic [15:0] b);
		req_type = OP_WRITE;
		write_face = 3'(f);
		write_x = 6'(x);
		write_y = 6'(y);
		write_red = r;
		write_green = g;
		write_blue = b;
		dir_x = 16'($urandom);
		dir_y = 16'($urandom);
		dir_z = 16'($urandom);
		if (f < FACE_COUNT) loaded[(f * 64 + y) * 64 + x] = 1'b1;
		issue();
		pause();
	endtask

	task automatic look(int dx, int dy, int dz);
		req_type = OP_SAMPLE;
		dir_x = 16'(dx);
		dir_y = 16'(dy);
		dir_z = 16'(dz);
		write_face = 3'($urandom);
		write_x = 6'($urandom);
		write_y = 6'($urandom);
		write_red = 16'($urandom);
		write_green = 16'($urandom);
		write_blue = 16'($urandom);
		issue();
		pause();
	endtask

	// minor components within 1/16 of the major one land inside the loaded window
	task automatic look_centre();
		int m, k, a, b, sel;
		m = $urandom_range(16, 32767);
		k = m / 16;
		a = int'($urandom_range(0, 2 * k)) - k;
		b = int'($urandom_range(0, 2 * k)) - k;
		if ($urandom_range(0, 1) == 1) m = -m;
		sel = $urandom_range(0, 2);
		if (sel == 0) look(m, a, b);
		else if (sel == 1) look(a, m, b);
		else look(a, b, m);
	endtask

	// drain, write the register, load texels in reach; only the window at size 64
	task automatic set_edge(int v);
		int sz;
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		face_size_we = 1'b1;
		face_size = 7'(v);
		@(negedge clk);
		face_size_we = 1'b0;
		sz = v > 64 ? 64 : v;
		centre_only = (sz == 64);
		if (centre_only) begin
			for (int f = 0; f < FACE_COUNT; f++)
				for (int y = WIN_LO; y <= WIN_HI; y++)
					for (int x = WIN_LO; x <= WIN_HI; x++)
						if (!loaded[(f * 64 + y) * 64 + x])
							put_texel(f, x, y, 16'($urandom), 16'($urandom), 16'($urandom));
		end else begin
			for (int f = 0; f < FACE_COUNT; f++)
				for (int y = 0; y < sz; y++)
					for (int x = 0; x < sz; x++)
						if (!loaded[(f * 64 + y) * 64 + x])
							put_texel(f, x, y, 16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	function automatic int pick_dir();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32767 : -32768;
			1: return int'($urandom_range(0, 16)) - 8;
			2: return 0;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	task automatic random_item();
		int a, k;
		if ($urandom_range(0, 9) < 6) begin
			a = pick_dir();
			k = $urandom_range(0, 5);
			if (centre_only) look_centre();
			// force ties between axes now and then
			else if (k == 0) look(a, $urandom_range(0, 1) ? a : -a, pick_dir());
			else if (k == 1) look(pick_dir(), a, $urandom_range(0, 1) ? a : -a);
			else if (k == 2) look(a, a, a);
			else look(pick_dir(), pick_dir(), pick_dir());
		end else begin
			put_texel($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 63),
				16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int edges [7] = '{1, 4, 2, 64, 127, 7, 3};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no map: black, but the face still reported; zero direction picks -x
		look(0, 0, 0);
		look(32767, 0, 0);
		look(-32768, 0, 0);
		look(0, 32767, 0);
		look(0, -32768, 0);
		look(0, 0, 32767);
		look(0, 0, -32768);
		set_edge(1);
		look(5, 5, 5);
		look(-3, 3, 1);
		set_edge(4);
		put_texel(0, 0, 0, 16'hffff, 16'h0000, 16'hffff);
		put_texel(6, 1, 1, 16'h1234, 16'h1234, 16'h1234);
		put_texel(7, 63, 63, 16'hffff, 16'hffff, 16'hffff);
		put_texel(1, 63, 63, 16'h0000, 16'hffff, 16'h0000);
		look(32767, 32767, 32767);
		look(-32768, -32768, -32768);
		look(32767, -32768, 100);
		look(-1, 0, 0);
		look(100, -100, 100);
		look(0, 0, 0);
		look(-32768, 32767, -32768);

		for (int p = 0; p < 7; p++) begin
			set_edge(edges[p]);
			gap_max = (p % 3 == 2) ? 0 : 40;
			for (int i = 0; i < 150; i++) random_item();
		end
		set_edge(0);
		for (int i = 0; i < 20; i++) random_item();

		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		$display("requests taken %0d, results checked %0d, face sizes 0,1,2,3,4,7,64 and 127",
			requests, samples_seen);
		if (errors == 0)
			$display("cube_map_bilinear_sampler_tb: clean");
		else
			$display("cube_map_bilinear_sampler_tb: errors");
		$finish;
	end
endmodule
